### rtl/core/bsa_pkg.sv
// Package for the bilinear splat accumulator: fixed-point formats, widths,
// register indexes and the per-axis mapping function.
// Depends on nothing; used by every file in rtl/core.
`default_nettype none

package bsa_pkg;

    // Fixed-point format of coordinates, weights and shares.
    localparam int FRAC_BITS = 8;
    localparam int SHARE_W   = FRAC_BITS + 1;

    // Accumulator widths.
    localparam int SUM_W = 40;
    localparam int WT_W  = 24;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Tile sizes and axis indexes fit in this many bits.
    localparam int SIZE_W = 12;
    localparam int FL_W   = PROD_W - 2 * FRAC_BITS + 1;

    // Divider widths.
    localparam int NUM_W = SUM_W + 1;
    localparam int QUO_W = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_TILE_HEIGHT = 3'd0;
    localparam logic [2:0] REG_TILE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_ROW  = 3'd2;
    localparam logic [2:0] REG_ORIGIN_COL  = 3'd3;
    localparam logic [2:0] REG_MAP_SCALE   = 3'd4;
    localparam logic [2:0] REG_BANDS       = 3'd5;

    // Operation codes.
    localparam logic [1:0] OP_SPLAT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [SHARE_W-1:0] ONE_FX = SHARE_W'(1 << FRAC_BITS);

    // Result of mapping one axis: neighbor indexes and the low-side weight.
    typedef struct packed {
        logic               ok;
        logic [SIZE_W-1:0]  lo;
        logic [SIZE_W-1:0]  hi;
        logic [SHARE_W-1:0] w;
    } axis_t;

    // Takes the product scale * (src - origin) and finds floor and ceiling
    // pixel indexes with edge clamping.
    function automatic axis_t map_axis(input logic signed [PROD_W-1:0] p,
                                       input logic [SIZE_W-1:0] size);
        logic signed [FL_W-1:0] fl;
        logic signed [FL_W-1:0] ce;
        logic signed [FL_W-1:0] sz;
        logic [FRAC_BITS-1:0]   frac;
        logic                   nz;
        logic [SHARE_W-1:0]     w;
        axis_t                  r;
        fl   = FL_W'(p >>> (2 * FRAC_BITS));
        frac = p[2*FRAC_BITS-1:FRAC_BITS];
        nz   = |frac;
        ce   = fl + FL_W'(nz);
        sz   = FL_W'(size);
        w    = nz ? (ONE_FX - {1'b0, frac}) : '0;
        r.ok = !(fl >= sz) && !(ce < 0);
        if (ce >= sz) begin
            ce = fl;
            w  = ONE_FX;
        end
        if (fl < 0) begin
            fl = ce;
            w  = ONE_FX;
        end
        r.lo = fl[SIZE_W-1:0];
        r.hi = ce[SIZE_W-1:0];
        r.w  = w;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bilinear_splat_accumulator.sv
// Top level of the bilinear splat accumulator: sequencer, tile memories,
// configuration registers. Depends on bsa_pkg, bsa_mul and bsa_div.
//
//  Channel   Direction  Word contents
//  s_        in         op, coord_valid in tuser; coordinates, band, sample, pixel in tdata
//  m_        out        pixel_value in tdata; covered in tuser
//  APB       in/out     six registers at byte address 4*i
//
// A splat runs two axis products (S_MR, S_MC) and S_AX, then three states per corner
// (S_SH, S_VM, S_WB) on the shared multiplier and memory; a dropped one returns to idle early.
// A read passes S_RA, S_RB and S_OUT, with S_DIV before S_OUT when the bit-serial divider runs or saturates.
// A clear, and the pass after reset, write one pixel a cycle over every pixel of the tile memories.
// Reset is synchronous. One result waits in the output register; a second
// read result then stalls the sequencer and the input.
`default_nettype none

module bilinear_splat_accumulator #(
    parameter int MAX_TILE_SIDE = 128,
    parameter int BANDS         = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [24:0] src_row, [49:25] src_col, [52:50] band, [68:53] sample_value,
    // [75:69] pixel_row, [82:76] pixel_col, [87:83] zero
    input  wire logic [87:0] s_tdata,
    // [1:0] op, [2] coord_valid
    input  wire logic [2:0]  s_tuser,
    // Result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] pixel_value
    output logic [15:0]      m_tdata,
    // [0] covered
    output logic             m_tuser
);
    import bsa_pkg::*;

    localparam int PIXELS = MAX_TILE_SIDE * MAX_TILE_SIDE;
    localparam int AW     = $clog2(PIXELS);
    localparam int RW     = $clog2(MAX_TILE_SIDE);
    localparam int BIW    = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam logic [SIZE_W-1:0] MAX_SIDE = SIZE_W'(MAX_TILE_SIDE);
    localparam logic [9:0]        MAX_BAND = 10'(BANDS);

    typedef enum logic [3:0] {
        S_IDLE, S_MR, S_MC, S_AX, S_SH, S_VM, S_WB,
        S_RA, S_RB, S_DIV, S_OUT, S_CLR
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [7:0]         tile_height_reg;
    logic [7:0]         tile_width_reg;
    logic signed [24:0] origin_row_reg;
    logic signed [24:0] origin_col_reg;
    logic [15:0]        map_scale_reg;
    logic [3:0]         bands_reg;

    // Latched item.
    logic signed [24:0] src_row_reg;
    logic signed [24:0] src_col_reg;
    logic [2:0]         band_reg;
    logic [15:0]        val_reg;
    logic [6:0]         prow_reg;
    logic [6:0]         pcol_reg;

    // Splat geometry.
    logic [RW-1:0]      r0_reg, r1_reg, c0_reg, c1_reg;
    logic [SHARE_W-1:0] wr_reg, wc_reg;
    logic               row_ok_reg;
    logic [1:0]         corner_reg;
    logic [SHARE_W-1:0] share_reg;
    logic [AW-1:0]      clr_reg;

    // Result registers.
    logic [15:0] res_val_reg;
    logic        res_cov_reg;
    logic        m_tvalid_reg;
    logic [15:0] m_data_reg;
    logic        m_cov_reg;

    // Tile memories, one row of band sums per pixel.
    logic [BANDS-1:0][SUM_W-1:0] sum_mem [PIXELS];
    logic [WT_W-1:0]             wt_mem  [PIXELS];
    logic [BANDS-1:0][SUM_W-1:0] sum_rdata_reg;
    logic [WT_W-1:0]             wt_rdata_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_raddr, mem_waddr, corner_addr;
    logic [BANDS-1:0][SUM_W-1:0] sum_wdata;
    logic [WT_W-1:0]             wt_wdata;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic [SIZE_W-1:0]  tile_h, tile_w;
    logic [9:0]         eff_bands;
    logic               band_ok;
    axis_t              axis;
    logic [SHARE_W-1:0] wa, wb, share;
    logic [2*FRAC_BITS+1:0] share_raw;
    logic [BIW-1:0]     band_idx;
    logic [SUM_W-1:0]   sum_old;
    logic [SUM_W:0]     sum_add;
    logic [WT_W:0]      wt_add;
    logic               in_tile;
    logic [NUM_W-1:0]   div_num;
    logic               div_start, div_done;
    logic [QUO_W-1:0]   div_quot;
    logic               cfg_we;

    // Effective sizes and band count after clamping.
    always_comb begin
        if (tile_height_reg == 8'd0) tile_h = SIZE_W'(1);
        else if ({4'b0, tile_height_reg} > MAX_SIDE) tile_h = MAX_SIDE;
        else tile_h = {4'b0, tile_height_reg};
        if (tile_width_reg == 8'd0) tile_w = SIZE_W'(1);
        else if ({4'b0, tile_width_reg} > MAX_SIDE) tile_w = MAX_SIDE;
        else tile_w = {4'b0, tile_width_reg};
        if (bands_reg == 4'd0) eff_bands = 10'd1;
        else if ({6'b0, bands_reg} > MAX_BAND) eff_bands = MAX_BAND;
        else eff_bands = {6'b0, bands_reg};
    end

    assign band_ok  = {7'b0, band_reg} < eff_bands;
    assign band_idx = BIW'(band_reg);
    assign in_tile  = ({5'b0, prow_reg} < tile_h) && ({5'b0, pcol_reg} < tile_w);

    // Axis mapping from the product, row during S_MC and column during S_AX.
    assign axis = map_axis(prod, (state_reg == S_MC) ? tile_h : tile_w);

    // Corner weights and rounded share.
    assign wa        = corner_reg[1] ? (ONE_FX - wr_reg) : wr_reg;
    assign wb        = corner_reg[0] ? (ONE_FX - wc_reg) : wc_reg;
    assign share_raw = prod[2*FRAC_BITS+1:0] + (2*FRAC_BITS+2)'(1 << (FRAC_BITS - 1));
    assign share     = share_raw[2*FRAC_BITS:FRAC_BITS];

    // Shared multiplier operand selection.
    always_comb begin
        case (state_reg)
            S_MR: begin
                mul_a = {{2{src_row_reg[24]}}, src_row_reg}
                      - {{2{origin_row_reg[24]}}, origin_row_reg};
                mul_b = {2'b00, map_scale_reg};
            end
            S_MC: begin
                mul_a = {{2{src_col_reg[24]}}, src_col_reg}
                      - {{2{origin_col_reg[24]}}, origin_col_reg};
                mul_b = {2'b00, map_scale_reg};
            end
            S_SH: begin
                mul_a = MUL_A_W'(wa);
                mul_b = MUL_B_W'(wb);
            end
            S_VM: begin
                mul_a = MUL_A_W'(val_reg);
                mul_b = MUL_B_W'(share);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bsa_mul u_mul (
        .aclk     (aclk),
        .a_in     (mul_a),
        .b_in     (mul_b),
        .prod_reg (prod)
    );

    // Memory addressing and write data.
    assign corner_addr = AW'((corner_reg[1] ? r1_reg : r0_reg) * MAX_TILE_SIDE
                           + (corner_reg[0] ? c1_reg : c0_reg));
    assign sum_old     = sum_rdata_reg[band_idx];
    assign sum_add     = {1'b0, sum_old} + (SUM_W+1)'(prod[24:0]);
    assign wt_add      = {1'b0, wt_rdata_reg} + (WT_W+1)'(share_reg);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = corner_addr;
        mem_raddr = corner_addr;
        sum_wdata = sum_rdata_reg;
        wt_wdata  = wt_rdata_reg;
        if (state_reg == S_RA) begin
            mem_raddr = in_tile ? AW'(RW'(prow_reg) * MAX_TILE_SIDE + RW'(pcol_reg)) : '0;
        end
        if (state_reg == S_WB) begin
            mem_we = 1'b1;
            sum_wdata[band_idx] = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (band_reg == 3'd0) begin
                wt_wdata = wt_add[WT_W] ? '1 : wt_add[WT_W-1:0];
            end
        end
        if (state_reg == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            sum_wdata = '0;
            wt_wdata  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sum_mem[mem_waddr] <= sum_wdata;
            wt_mem[mem_waddr]  <= wt_wdata;
        end
        sum_rdata_reg <= sum_mem[mem_raddr];
        wt_rdata_reg  <= wt_mem[mem_raddr];
    end

    // Rounded division of the band sum by the pixel weight.
    assign div_num   = {1'b0, sum_old} + NUM_W'(wt_rdata_reg >> 1);
    assign div_start = (state_reg == S_RB) && in_tile && (wt_rdata_reg != '0) && band_ok;

    bsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (wt_rdata_reg),
        .done_reg (div_done),
        .quot_reg (div_quot)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        case (paddr[4:2])
            REG_TILE_HEIGHT: prdata = {24'b0, tile_height_reg};
            REG_TILE_WIDTH:  prdata = {24'b0, tile_width_reg};
            REG_ORIGIN_ROW:  prdata = {7'b0, origin_row_reg};
            REG_ORIGIN_COL:  prdata = {7'b0, origin_col_reg};
            REG_MAP_SCALE:   prdata = {16'b0, map_scale_reg};
            REG_BANDS:       prdata = {28'b0, bands_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_height_reg <= 8'd128;
            tile_width_reg  <= 8'd128;
            origin_row_reg  <= '0;
            origin_col_reg  <= '0;
            map_scale_reg   <= 16'd256;
            bands_reg       <= 4'd8;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_TILE_HEIGHT: tile_height_reg <= pwdata[7:0];
                REG_TILE_WIDTH:  tile_width_reg  <= pwdata[7:0];
                REG_ORIGIN_ROW:  origin_row_reg  <= pwdata[24:0];
                REG_ORIGIN_COL:  origin_col_reg  <= pwdata[24:0];
                REG_MAP_SCALE:   map_scale_reg   <= pwdata[15:0];
                REG_BANDS:       bands_reg       <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            corner_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // S_OUT drives the valid flag itself when it hands over a result.
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        src_row_reg <= s_tdata[24:0];
                        src_col_reg <= s_tdata[49:25];
                        band_reg    <= s_tdata[52:50];
                        val_reg     <= s_tdata[68:53];
                        prow_reg    <= s_tdata[75:69];
                        pcol_reg    <= s_tdata[82:76];
                        case (s_tuser[1:0])
                            OP_SPLAT: begin
                                if (s_tuser[2]) state_reg <= S_MR;
                            end
                            OP_READ:  state_reg <= S_RA;
                            OP_CLEAR: begin
                                clr_reg   <= '0;
                                state_reg <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MR: begin
                    state_reg <= band_ok ? S_MC : S_IDLE;
                end
                S_MC: begin
                    r0_reg     <= RW'(axis.lo);
                    r1_reg     <= RW'(axis.hi);
                    wr_reg     <= axis.w;
                    row_ok_reg <= axis.ok;
                    state_reg  <= S_AX;
                end
                S_AX: begin
                    c0_reg     <= RW'(axis.lo);
                    c1_reg     <= RW'(axis.hi);
                    wc_reg     <= axis.w;
                    corner_reg <= '0;
                    state_reg  <= (row_ok_reg && axis.ok) ? S_SH : S_IDLE;
                end
                S_SH: begin
                    state_reg <= S_VM;
                end
                S_VM: begin
                    share_reg <= share;
                    state_reg <= S_WB;
                end
                S_WB: begin
                    corner_reg <= corner_reg + 2'd1;
                    state_reg  <= (corner_reg == 2'd3) ? S_IDLE : S_SH;
                end
                S_RA: begin
                    state_reg <= S_RB;
                end
                S_RB: begin
                    if (div_start) begin
                        state_reg <= S_DIV;
                    end else begin
                        res_val_reg <= '0;
                        res_cov_reg <= in_tile && (wt_rdata_reg != '0);
                        state_reg   <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        res_val_reg <= div_quot;
                        res_cov_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= res_val_reg;
                        m_cov_reg    <= res_cov_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                S_CLR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(PIXELS - 1)) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_cov_reg;

    // An uncovered pixel always reads as zero.
    a_uncovered_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0))
        else $error("uncovered result with nonzero value");

    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider result outside of a read");

    // Weights change only for splats of band zero.
    a_weight_band0: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WB && band_reg != 3'd0) |-> (wt_wdata == wt_rdata_reg))
        else $error("weight written by a nonzero band");

endmodule

`default_nettype wire

### rtl/core/bsa_mul.sv
// Shared signed multiplier of the splat accumulator, one registered product.
// Depends on bsa_pkg for operand widths.
`default_nettype none

module bsa_mul (
    input  wire logic                               aclk,
    input  wire logic signed [bsa_pkg::MUL_A_W-1:0] a_in,
    input  wire logic signed [bsa_pkg::MUL_B_W-1:0] b_in,
    output logic signed [bsa_pkg::PROD_W-1:0]       prod_reg
);
    import bsa_pkg::*;

    // The product is registered and appears in the cycle after its operands.
    always_ff @(posedge aclk) begin
        prod_reg <= a_in * b_in;
    end

endmodule

`default_nettype wire

### rtl/core/bsa_div.sv
// Bit-serial restoring divider giving round-ready quotients saturated to 16 bits.
// Depends on bsa_pkg for widths.
`default_nettype none

module bsa_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [bsa_pkg::NUM_W-1:0]  num,
    input  wire logic [bsa_pkg::WT_W-1:0]   den,
    output logic                            done_reg,
    output logic [bsa_pkg::QUO_W-1:0]       quot_reg
);
    import bsa_pkg::*;

    logic            busy_reg;
    logic [4:0]      cnt_reg;
    logic [WT_W-1:0] rem_reg;
    logic [WT_W-1:0] den_reg;
    logic [WT_W:0]   rem_sh;
    logic            ge;

    // One quotient bit per cycle against the divisor held at start.
    assign rem_sh = {rem_reg, quot_reg[QUO_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // A quotient above 16 bits saturates at once.
                if (num[NUM_W-1:QUO_W] >= {1'b0, den}) begin
                    quot_reg <= '1;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= num[NUM_W-2:QUO_W];
                    quot_reg <= num[QUO_W-1:0];
                    den_reg  <= den;
                    cnt_reg  <= 5'(QUO_W);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg  <= ge ? WT_W'(rem_sh - {1'b0, den_reg}) : rem_sh[WT_W-1:0];
                quot_reg <= {quot_reg[QUO_W-2:0], ge};
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for bilinear_splat_accumulator: drives splat, read and clear
// words, keeps its own copy of the tile stores and checks every pixel read result.
// Depends on bsa_pkg and the bilinear_splat_accumulator RTL.
`timescale 1ns / 1ps

module testbench;
    import bsa_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int SIDE = 128;
    localparam int NBANDS = 8;
    localparam longint SUM_SAT = (64'd1 << 40) - 1;
    localparam longint WT_SAT = (64'd1 << 24) - 1;

    typedef struct {
        logic [1:0]         op;
        logic signed [24:0] src_row;
        logic signed [24:0] src_col;
        logic               coord_valid;
        logic [2:0]         band;
        logic [15:0]        sample;
        logic [6:0]         prow;
        logic [6:0]         pcol;
    } word_t;

    typedef struct {
        logic [15:0] value;
        logic        covered;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    bilinear_splat_accumulator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the tile stores and registers.
    logic [39:0] sum_store [SIDE*SIDE*NBANDS];
    logic [23:0] weight_store [SIDE*SIDE];
    logic [7:0]  cfg_height, cfg_width;
    logic [24:0] cfg_org_row, cfg_org_col;
    logic [15:0] cfg_scale;
    logic [3:0]  cfg_bands;

    pixel_t expected_pixels [$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_request = 0;

    function automatic void clear_tile();
        foreach (sum_store[i]) sum_store[i] = '0;
        foreach (weight_store[i]) weight_store[i] = '0;
    endfunction

    function automatic int tile_side(logic [7:0] v);
        return (v < 1) ? 1 : (v > SIDE) ? SIDE : int'(v);
    endfunction

    function automatic int bands_used();
        return (cfg_bands < 1) ? 1 : (cfg_bands > NBANDS) ? NBANDS : int'(cfg_bands);
    endfunction

    // Maps one axis; returns 0 when the point is off the tile.
    function automatic bit axis_map(longint src, longint org, int size,
                                    output longint lo, output longint hi,
                                    output longint wlo);
        longint t, fl, frac, ce, w;
        t = (longint'(cfg_scale) * (src - org)) >>> FRAC_BITS;
        fl = t >>> FRAC_BITS;
        frac = t - (fl <<< FRAC_BITS);
        ce = fl + ((frac != 0) ? 1 : 0);
        w = (frac != 0) ? 256 - frac : 0;
        if (fl >= size || ce < 0) return 0;
        if (ce >= size) begin
            ce = fl;
            w = 256;
        end
        if (fl < 0) begin
            fl = ce;
            w = 256;
        end
        lo = fl;
        hi = ce;
        wlo = w;
        return 1;
    endfunction

    function automatic void add_share(longint r, longint c, int b, bit add_w,
                                      longint val, longint wa, longint wb);
        longint share, s, w;
        int px;
        share = (wa * wb + 128) >> 8;
        px = int'(r) * SIDE + int'(c);
        s = longint'(sum_store[px*NBANDS+b]) + val * share;
        sum_store[px*NBANDS+b] = (s > SUM_SAT) ? SUM_SAT[39:0] : s[39:0];
        if (add_w) begin
            w = longint'(weight_store[px]) + share;
            weight_store[px] = (w > WT_SAT) ? WT_SAT[23:0] : w[23:0];
        end
    endfunction

    function automatic void accumulate_splat(word_t wd);
        longint r0, r1, wr, c0, c1, wc;
        bit add_w;
        if (!wd.coord_valid || int'(wd.band) >= bands_used()) return;
        if (!axis_map(wd.src_row, $signed(cfg_org_row), tile_side(cfg_height), r0, r1, wr))
            return;
        if (!axis_map(wd.src_col, $signed(cfg_org_col), tile_side(cfg_width), c0, c1, wc))
            return;
        add_w = (wd.band == 0);
        add_share(r0, c0, wd.band, add_w, wd.sample, wr, wc);
        add_share(r0, c1, wd.band, add_w, wd.sample, wr, 256 - wc);
        add_share(r1, c0, wd.band, add_w, wd.sample, 256 - wr, wc);
        add_share(r1, c1, wd.band, add_w, wd.sample, 256 - wr, 256 - wc);
    endfunction

    function automatic pixel_t predict_read(word_t wd);
        pixel_t p;
        longint wt, s, q;
        int px;
        p.value = '0;
        p.covered = 1'b0;
        if (int'(wd.prow) < tile_side(cfg_height) && int'(wd.pcol) < tile_side(cfg_width)) begin
            px = int'(wd.prow) * SIDE + int'(wd.pcol);
            wt = weight_store[px];
            if (wt > 0) begin
                p.covered = 1'b1;
                if (int'(wd.band) < bands_used()) begin
                    s = sum_store[px*NBANDS+wd.band];
                    q = (s + wt / 2) / wt;
                    p.value = (q > 65535) ? 16'hFFFF : q[15:0];
                end
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result word", m_tdata, -1);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want.value) report_mismatch("pixel_value", m_tdata, want.value);
                if (m_tuser !== want.covered) report_mismatch("covered", m_tuser, want.covered);
            end
        end
    end

    // Receiver: random stalls plus a counted hold-off on request.
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_request <= hold_request - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TILE_HEIGHT: cfg_height = val[7:0];
            REG_TILE_WIDTH:  cfg_width = val[7:0];
            REG_ORIGIN_ROW:  cfg_org_row = val[24:0];
            REG_ORIGIN_COL:  cfg_org_col = val[24:0];
            REG_MAP_SCALE:   cfg_scale = val[15:0];
            REG_BANDS:       cfg_bands = val[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(int h, int w, int orow, int ocol, int scale, int nb);
        write_reg(REG_TILE_HEIGHT, h);
        write_reg(REG_TILE_WIDTH, w);
        write_reg(REG_ORIGIN_ROW, orow);
        write_reg(REG_ORIGIN_COL, ocol);
        write_reg(REG_MAP_SCALE, scale);
        write_reg(REG_BANDS, nb);
    endtask

    // Sends one word; called at a falling edge and returns at one.
    task automatic send_word(word_t wd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, wd.pcol, wd.prow, wd.sample, wd.band, wd.src_col, wd.src_row};
        s_tuser <= {wd.coord_valid, wd.op};
        do @(posedge aclk); while (!s_tready);
        case (wd.op)
            OP_SPLAT: accumulate_splat(wd);
            OP_READ:  expected_pixels.insert(expected_pixels.size(), predict_read(wd));
            OP_CLEAR: clear_tile();
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Waits until every result is in and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0 || !s_tready) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic word_t splat_word(int r, int c, int b, int v);
        word_t wd;
        wd = '{op: OP_SPLAT, src_row: r, src_col: c, coord_valid: 1'b1, band: b,
               sample: v, prow: '0, pcol: '0};
        return wd;
    endfunction

    function automatic word_t read_word(int r, int c, int b);
        word_t wd;
        wd = '{op: OP_READ, src_row: '0, src_col: '0, coord_valid: 1'b0, band: b,
               sample: '0, prow: r, pcol: c};
        return wd;
    endfunction

    // Source coordinate that lands near the tile along one axis.
    function automatic int near_coord(logic [24:0] org, int size);
        longint d, s;
        d = longint'($urandom_range(size * 256 + 1200)) - 600;
        if ($urandom_range(3) == 0) d = d & ~longint'(255);
        s = longint'($signed(org)) + (d * 256) / longint'(cfg_scale);
        if (s > 16777215) s = 16777215;
        if (s < -16777216) s = -16777216;
        return int'(s);
    endfunction

    function automatic word_t random_word();
        word_t wd;
        int pick;
        pick = $urandom_range(99);
        wd.op = OP_READ;
        wd.src_row = $urandom;
        wd.src_col = $urandom;
        wd.coord_valid = $urandom;
        wd.band = $urandom;
        wd.sample = $urandom;
        wd.prow = $urandom_range(tile_side(cfg_height) + 1);
        wd.pcol = $urandom_range(tile_side(cfg_width) + 1);
        if (pick < 60) begin
            wd.op = OP_SPLAT;
            wd.coord_valid = 1'b1;
            wd.band = $urandom_range(bands_used() - 1);
            if ($urandom_range(2) == 0) wd.band = 0;
            wd.src_row = near_coord(cfg_org_row, tile_side(cfg_height));
            wd.src_col = near_coord(cfg_org_col, tile_side(cfg_width));
        end else if (pick >= 92) begin
            wd.op = ($urandom_range(1) == 0) ? OP_NONE : 2'($urandom_range(1));
            wd.prow = $urandom;
            wd.pcol = $urandom;
        end
        return wd;
    endfunction

    // Extremes of every field and each special case of the mapping.
    task automatic test_directed();
        configure(8, 8, 0, 0, 256, 8);
        send_word(splat_word(2 * 256, 3 * 256, 0, 1000));
        send_word(splat_word(2 * 256, 3 * 256, 1, 65535));
        send_word(splat_word(2 * 256 + 128, 3 * 256 + 64, 0, 500));
        send_word(splat_word(2 * 256 + 128, 3 * 256 + 64, 7, 0));
        send_word(splat_word(-100, 5 * 256, 0, 777));
        send_word(splat_word(7 * 256 + 200, 7 * 256 + 1, 0, 4321));
        send_word(splat_word(-256, 0, 0, 9));
        send_word(splat_word(8 * 256, 0, 0, 9));
        send_word(splat_word(-16777216, 16777215, 0, 9));
        send_word(splat_word(16777215, -16777216, 3, 9));
        begin
            word_t wd;
            wd = splat_word(256, 256, 0, 50);
            wd.coord_valid = 1'b0;
            send_word(wd);
            wd.op = OP_NONE;
            wd.coord_valid = 1'b1;
            send_word(wd);
        end
        send_word(read_word(2, 3, 0));
        send_word(read_word(2, 3, 1));
        send_word(read_word(2, 4, 0));
        send_word(read_word(3, 4, 7));
        send_word(read_word(0, 5, 0));
        send_word(read_word(7, 7, 0));
        send_word(read_word(1, 1, 0));
        send_word(read_word(127, 127, 0));
        send_word(read_word(0, 0, 0));
        wait_idle();
        // Band limit: splats and reads at or past it.
        write_reg(REG_BANDS, 2);
        send_word(splat_word(256, 256, 2, 100));
        send_word(splat_word(256, 256, 0, 100));
        send_word(read_word(1, 1, 5));
        send_word(read_word(1, 1, 0));
        wait_idle();
    endtask

    // Out-of-range and extreme register values.
    task automatic test_register_extremes();
        configure(0, 255, -16777216, 16777215, 1, 0);
        send_word(splat_word(-16777216, 16777215, 0, 65535));
        send_word(splat_word(16777215, 16777215, 0, 1));
        send_word(read_word(0, 0, 0));
        send_word(read_word(0, 127, 1));
        wait_idle();
        configure(255, 0, 16777215, -16777216, 65535, 15);
        send_word(splat_word(16777215, -16777216, 0, 300));
        send_word(splat_word(16777215, -16777216 + 1, 7, 300));
        send_word(read_word(0, 0, 0));
        send_word(read_word(0, 0, 7));
        send_word(read_word(127, 0, 0));
        wait_idle();
    endtask

    // Clear wipes both stores; the reads after it wait out the clearing pass.
    task automatic test_clear();
        word_t wd;
        configure(4, 4, 0, 0, 256, 8);
        send_word(splat_word(256, 256, 0, 200));
        send_word(read_word(1, 1, 0));
        wd = read_word(0, 0, 0);
        wd.op = OP_CLEAR;
        send_word(wd);
        send_word(read_word(1, 1, 0));
        send_word(splat_word(256, 256, 0, 30));
        send_word(read_word(1, 1, 0));
        wait_idle();
    endtask

    // Long receiver hold-off while reads keep coming, then a sender pause.
    task automatic test_backpressure();
        configure(4, 4, 0, 0, 256, 4);
        for (int i = 0; i < 16; i++) send_word(random_word());
        wait_idle();
        hold_request = 400;
        for (int i = 0; i < 40; i++) send_word(read_word($urandom_range(3), $urandom_range(3), 0));
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        for (int i = 0; i < 20; i++) send_word(random_word());
        wait_idle();
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) send_word(random_word());
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_random();
        word_t clr;
        clr = read_word(0, 0, 0);
        clr.op = OP_CLEAR;
        configure(3, 5, 1000, -2000, 256, 8);
        run_phase(160, 0, 0);
        run_phase(160, 87, 0);
        configure(8, 2, -5000, 70000, 384, 3);
        run_phase(160, 0, 87);
        run_phase(160, 31, 31);
        send_word(clr);
        wait_idle();
        configure(1, 1, 0, 0, 200, 1);
        run_phase(120, 0, 0);
        configure(6, 6, 12345, -12345, 128, 8);
        run_phase(160, 31, 31);
        send_word(clr);
        wait_idle();
        configure(128, 128, 0, 0, 65535, 8);
        run_phase(120, 87, 0);
        configure(16, 16, -300, 300, 1, 8);
        run_phase(120, 0, 87);
    endtask

    initial begin
        cfg_height = 128; cfg_width = 128;
        cfg_org_row = '0; cfg_org_col = '0;
        cfg_scale = 256; cfg_bands = 8;
        clear_tile();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // The block clears its stores after reset before it takes words.
        wait_idle();
        test_directed();
        test_register_extremes();
        test_clear();
        test_backpressure();
        test_random();
        repeat (50) @(negedge aclk);
        if (errors == 0) begin
            $display("bilinear_splat_accumulator verification clean");
        end else begin
            $display("bilinear_splat_accumulator verification failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("bilinear_splat_accumulator verification failed");
        $finish;
    end

endmodule
